// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_PROP(label, !(expr), msg)

`endif

// ===== design/bpa_pkg.sv =====
// Codes and fixed constants of the bitmap page allocator.
package bpa_pkg;

	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_WAS_FREE  = 2'd3;

	localparam logic [1:0] CFG_MEM_VALID = 2'd0;
	localparam logic [1:0] CFG_MEM_LOWER = 2'd1;
	localparam logic [1:0] CFG_MEM_UPPER = 2'd2;
	localparam logic [1:0] CFG_KERN_END  = 2'd3;

	localparam logic [31:0] BITMAP_AREA_BYTES = 32'h0002_0000;
	localparam logic [31:0] DEFAULT_MEMORY    = 32'h0200_0000;
	localparam int          KB_SHIFT          = 10;

endpackage

// ===== design/bpa_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/bitmap_page_allocator_top.sv =====
// Bitmap page allocator: first-fit page frame map held in one RAM.
//
//  channel  dir  handshake          word
//  in       in   in_valid/in_stall  req_type, page_addr
//  out      out  out_valid/out_stall status, alloc_addr, total/used/free bytes
//  cfg      in   cfg_wr_en          cfg_index, cfg_wr_data
//
// Init: setup states S_INIT1 and S_INIT2, then S_FILL writes all MAP_WORDS map words, one per cycle, then the result.
// Alloc: one map word read per cycle, scanning up to ceil(page_total/32) words, then the result.
// Free: read, check and write back, result; NOP and an out-of-range free go straight to the result.
// Reset clears control and counters; the map is undefined until the first init.
// One request in flight; the result cycle waits while out_stall holds a full output.
module bitmap_page_allocator_top
	import bpa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096,
	parameter int MAX_PAGES  = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] page_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] alloc_addr,
	output logic [31:0] total_bytes,
	output logic [31:0] used_bytes,
	output logic [31:0] free_bytes
);

	localparam int PB_LOG2   = $clog2(PAGE_BYTES);
	localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
	localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int WCW       = AW + 1;
	localparam int CW        = $clog2(MAX_PAGES + 1);
	localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_INIT1, S_INIT2, S_FILL, S_ASCAN, S_FRD, S_FCHK, S_DONE
	} state_t;

	state_t state_q;

	logic        mem_valid_q;
	logic [31:0] mem_lower_q, mem_upper_q, kern_end_q;

	logic [31:0]    memory_total_q;
	logic [CW-1:0]  page_total_q, used_q;
	logic [WCW-1:0] nwords_q;
	logic [31:0]    kend_up_q, start_q;
	logic [WCW-1:0] fill_q, scan_q;
	logic           rv_s1;
	logic [AW-1:0]  rw_s1, fword_q;
	logic [4:0]     fbit_q;
	logic [1:0]     res_status_q;
	logic [31:0]    res_addr_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] alloc_addr_q, total_q, used_b_q, free_b_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	logic          accept, slot_free, found;
	logic [4:0]    zbit;
	logic [31:0]   mem_sum, mem_calc, pages_c, base_c, start_c, nw_c, fr_page;
	logic [CW-1:0] total_c, used_c, free_pages;
	logic [31:0]   fill_word;
	logic [63:0]   alloc_wide, used_wide, free_wide;

	function automatic logic [4:0] lowest_zero(logic [31:0] w);
		logic [4:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!w[i]) r = 5'(i);
		end
		return r;
	endfunction

	bpa_ram #(.WIDTH(32), .DEPTH(MAP_WORDS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign mem_sum  = mem_lower_q + mem_upper_q;
	assign mem_calc = mem_valid_q ? (mem_sum << KB_SHIFT) : DEFAULT_MEMORY;
	assign pages_c  = memory_total_q >> PB_LOG2;
	assign total_c  = (pages_c > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : pages_c[CW-1:0];
	assign base_c   = kend_up_q + BITMAP_AREA_BYTES;
	assign start_c  = base_c >> PB_LOG2;
	assign used_c   = (start_c < 32'(total_c)) ? start_c[CW-1:0] : total_c;
	assign nw_c     = (32'(total_c) + 32'd31) >> 5;
	assign fr_page  = page_addr >> PB_LOG2;

	always_comb begin
		logic [31:0] pn;
		for (int b = 0; b < 32; b++) begin
			pn = (32'(fill_q) << 5) | 32'(b);
			fill_word[b] = !((pn >= start_q) && (pn < 32'(page_total_q)));
		end
	end

	assign found      = rv_s1 && (ram_rdata != '1);
	assign zbit       = lowest_zero(ram_rdata);
	assign alloc_wide = ((64'(rw_s1) << 5) | 64'(zbit)) << PB_LOG2;
	assign free_pages = page_total_q - used_q;
	assign used_wide  = 64'(used_q) << PB_LOG2;
	assign free_wide  = 64'(free_pages) << PB_LOG2;

	// Sequencer owns the map: every write lands before the next read starts.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_wdata = fill_word;
		ram_raddr = scan_q[AW-1:0];
		unique case (state_q)
			S_FILL: begin
				ram_we = 1'b1;
			end
			S_ASCAN: begin
				ram_we    = found;
				ram_waddr = rw_s1;
				ram_wdata = ram_rdata | (32'd1 << zbit);
			end
			S_FRD: begin
				ram_raddr = fword_q;
			end
			S_FCHK: begin
				ram_we    = ram_rdata[fbit_q];
				ram_waddr = fword_q;
				ram_wdata = ram_rdata & ~(32'd1 << fbit_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mem_valid_q    <= 1'b0;
			mem_lower_q    <= '0;
			mem_upper_q    <= '0;
			kern_end_q     <= '0;
			memory_total_q <= '0;
			page_total_q   <= '0;
			used_q         <= '0;
			nwords_q       <= '0;
			kend_up_q      <= '0;
			start_q        <= '0;
			fill_q         <= '0;
			scan_q         <= '0;
			rv_s1          <= 1'b0;
			rw_s1          <= '0;
			fword_q        <= '0;
			fbit_q         <= '0;
			res_status_q   <= ST_OK;
			res_addr_q     <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= ST_OK;
			alloc_addr_q   <= '0;
			total_q        <= '0;
			used_b_q       <= '0;
			free_b_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_MEM_VALID: mem_valid_q <= cfg_wr_data[0];
					CFG_MEM_LOWER: mem_lower_q <= cfg_wr_data;
					CFG_MEM_UPPER: mem_upper_q <= cfg_wr_data;
					CFG_KERN_END:  kern_end_q  <= cfg_wr_data;
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= ST_OK;
						res_addr_q   <= '0;
						unique case (req_type)
							REQ_INIT: state_q <= S_INIT1;
							REQ_ALLOC: begin
								scan_q  <= '0;
								rv_s1   <= 1'b0;
								state_q <= S_ASCAN;
							end
							REQ_FREE: begin
								if (fr_page >= 32'(page_total_q)) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else begin
									fword_q <= fr_page[AW+4:5];
									fbit_q  <= fr_page[4:0];
									state_q <= S_FRD;
								end
							end
							REQ_NOP: state_q <= S_DONE;
						endcase
					end
				end
				S_INIT1: begin
					memory_total_q <= mem_calc;
					kend_up_q      <= (kern_end_q + PAGE_MASK) & ~PAGE_MASK;
					state_q        <= S_INIT2;
				end
				S_INIT2: begin
					page_total_q <= total_c;
					used_q       <= used_c;
					start_q      <= start_c;
					nwords_q     <= nw_c[WCW-1:0];
					fill_q       <= '0;
					state_q      <= S_FILL;
				end
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == WCW'(MAP_WORDS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_ASCAN: begin
					if (found) begin
						used_q     <= used_q + 1'b1;
						res_addr_q <= alloc_wide[31:0];
						rv_s1      <= 1'b0;
						state_q    <= S_DONE;
					end else if (!rv_s1 && scan_q == nwords_q) begin
						res_status_q <= ST_NO_FREE;
						state_q      <= S_DONE;
					end else if (scan_q != nwords_q) begin
						rv_s1  <= 1'b1;
						rw_s1  <= scan_q[AW-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						rv_s1 <= 1'b0;
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (ram_rdata[fbit_q]) begin
						used_q <= used_q - 1'b1;
					end else begin
						res_status_q <= ST_WAS_FREE;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						alloc_addr_q <= res_addr_q;
						total_q      <= memory_total_q;
						used_b_q     <= used_wide[31:0];
						free_b_q     <= free_wide[31:0];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign alloc_addr  = alloc_addr_q;
	assign total_bytes = total_q;
	assign used_bytes  = used_b_q;
	assign free_bytes  = free_b_q;

endmodule

// ===== design/bpa_checker.sv =====
// Port-level checker for the bitmap page allocator, with its bind.
`include "assert_macros.svh"

module bpa_checker
	import bpa_pkg::*;
#(
	parameter int PAGE_BYTES = 4096
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] alloc_addr,
	input logic [31:0] total_bytes,
	input logic [31:0] used_bytes,
	input logic [31:0] free_bytes
);

	localparam int PB_LOG2 = $clog2(PAGE_BYTES);

	`ASSERT_PROP(a_in_taken, in_valid && !in_stall |=> in_stall, "accepted word left input open")

	`ASSERT_PROP(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status)
		&& $stable(alloc_addr) && $stable(total_bytes) && $stable(used_bytes)
		&& $stable(free_bytes), "stalled output word changed")

	`ASSERT_NEVER(a_fail_addr, out_valid && status != ST_OK && alloc_addr != 32'd0,
		"failed request carries an address")

	`ASSERT_NEVER(a_addr_align, out_valid && alloc_addr[PB_LOG2-1:0] != '0,
		"allocated address not page aligned")

	`ASSERT_NEVER(a_used_align, out_valid && (used_bytes[PB_LOG2-1:0] != '0
		|| free_bytes[PB_LOG2-1:0] != '0), "byte counts not whole pages")

endmodule

bind bitmap_page_allocator_top bpa_checker #(.PAGE_BYTES(PAGE_BYTES)) u_bpa_checker (.*);
